>>> src/chebyshev_richardson_solver_defines.svh
// Assertion macros for the Chebyshev-Richardson solver checker
`ifndef CHEBYSHEV_RICHARDSON_SOLVER_DEFINES_SVH
`define CHEBYSHEV_RICHARDSON_SOLVER_DEFINES_SVH

// same-cycle implication, masked in reset
`define CRS_CHK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crs check failed");

// next-cycle implication, masked in reset
`define CRS_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crs check failed");

// next-cycle implication, also active in reset
`define CRS_CHK_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crs reset check failed");

`endif

>>> src/crs_pkg.sv
// Shared types, constants and saturation helper for the solver
package crs_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 31;
  localparam int ITER_W = 16;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 35;

  localparam logic [2:0] CFG_SIZE  = 3'd0;
  localparam logic [2:0] CFG_ALPHA = 3'd1;
  localparam logic [2:0] CFG_BETA  = 3'd2;
  localparam logic [2:0] CFG_TOL   = 3'd3;
  localparam logic [2:0] CFG_LIMIT = 3'd4;

  typedef struct packed {
    logic                    go;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> src/crs_ram.sv
// Generic single-write, single-read RAM with registered read data
module crs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/crs_div.sv
// Radix-2 restoring signed divider, truncating, saturated to 32 bits
module crs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  crs_pkg::div_req_t req,
  output crs_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(crs_pkg::NUM_W);

  logic [crs_pkg::NUM_W-1:0] q_r;
  logic [crs_pkg::DEN_W-1:0] rem_r;
  logic [crs_pkg::DEN_W-1:0] dm_r;
  logic                      neg_r;
  logic                      run_r;
  logic                      done_r;
  logic [CW-1:0]             cnt_r;
  logic [crs_pkg::DEN_W:0]   shifted;
  logic [crs_pkg::DEN_W:0]   trial;

  assign shifted = {rem_r, q_r[crs_pkg::NUM_W-1]};
  assign trial   = shifted - {1'b0, dm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.go && run_r && (cnt_r == CW'(crs_pkg::NUM_W - 1));
      if (req.go) begin
        q_r   <= req.num[crs_pkg::NUM_W-1] ? crs_pkg::NUM_W'(-req.num)
                                           : crs_pkg::NUM_W'(req.num);
        dm_r  <= req.den[crs_pkg::DEN_W-1] ? crs_pkg::DEN_W'(-req.den)
                                           : crs_pkg::DEN_W'(req.den);
        neg_r <= req.num[crs_pkg::NUM_W-1] ^ req.den[crs_pkg::DEN_W-1];
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (!trial[crs_pkg::DEN_W]) begin
          rem_r <= trial[crs_pkg::DEN_W-1:0];
          q_r   <= {q_r[crs_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[crs_pkg::DEN_W-1:0];
          q_r   <= {q_r[crs_pkg::NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(crs_pkg::NUM_W - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    if (!neg_r) begin
      if (q_r > crs_pkg::NUM_W'(32'h7FFFFFFF)) rsp.quo = 32'sh7FFFFFFF;
      else rsp.quo = q_r[31:0];
    end else begin
      if (q_r >= crs_pkg::NUM_W'(33'h080000000)) rsp.quo = 32'sh80000000;
      else rsp.quo = 32'(-q_r[31:0]);
    end
  end

endmodule

>>> src/chebyshev_richardson_solver.sv
// Top level: Chebyshev-accelerated Richardson solver over RAM-held matrix and estimates
// Loading accepts one value per cycle while busy is low; busy rises only after the last of the n*(n+1) values.
// Solve: three divisions of setup, then per iteration one division plus the
// matrix-vector work and the update and copy of the estimates.
// Results then stream out one element at a time; the receiver never stalls them.
// Reset is synchronous, active low; a size write recomputes the load row and column from pos.
module chebyshev_richardson_solver #(
  parameter int MAX_UNKNOWNS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_load_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_solution_value,
  output logic [3:0]         out_element_index,
  output logic [15:0]        out_iteration_count,
  output logic               out_converged,
  output logic               out_last_of_run
);

  localparam int NW   = $clog2(MAX_UNKNOWNS + 1);
  localparam int IW   = MAX_UNKNOWNS > 1 ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int MD   = MAX_UNKNOWNS * MAX_UNKNOWNS;
  localparam int MAW  = MD > 1 ? $clog2(MD) : 1;
  localparam int POSW = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1) + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RESYNC, S_SETUP, S_DIV_GO, S_DIV_WT,
    S_X1_RD, S_X1_MUL, S_X1_WR,
    S_IT_DEN, S_IT_W, S_IT_C, S_IT_D, S_IT_E,
    S_MV_RD, S_MV_MUL, S_MV_ACC,
    S_RW_RD, S_RW_A, S_RW_B, S_RW_C, S_RW_D,
    S_CP_RD, S_CP_WR, S_IT_END,
    S_OUT_RD, S_OUT_EM
  } state_t;

  typedef enum logic [1:0] {SEL_D, SEL_T, SEL_OM, SEL_OM1} sel_t;

  state_t state_r;
  sel_t   sel_r;

  logic [4:0]  size_r;
  logic [30:0] alpha_r, beta_r, tol_r;
  logic [15:0] lim_r;
  logic        resync_r;

  logic [POSW-1:0] pos_r, col_r;
  logic [IW-1:0]   row_r, i_r, j_r;
  logic [15:0]     iter_r;
  logic            met_r, bad_r;

  logic signed [31:0] d_r, t1_r, omega_r, om1_r, w_r, dc_r;
  logic signed [31:0] r_r, dif_r, cur_i_r, t1v_r;
  logic signed [34:0] den_r;
  logic signed [39:0] acc_r;
  logic [32:0]        norm_r;
  logic signed [63:0] prod_r, prod_nxt;

  logic               out_valid_r, out_conv_r, out_last_r;
  logic signed [31:0] out_val_r;
  logic [3:0]         out_idx_r;
  logic [15:0]        out_iter_r;

  logic [NW-1:0]   n_act;
  logic [POSW-1:0] n_p, n1_p, total;
  logic [IW-1:0]   n_m1;
  logic            accept;
  logic [15:0]     lim_eff;

  logic [31:0]        s_sum;
  logic signed [32:0] diff_s;
  logic signed [34:0] den_c;
  logic signed [31:0] qm, coef, x2;
  logic signed [33:0] ch_s;
  logic [32:0]        ch_abs;
  logic signed [31:0] mul_a, mul_b;

  logic [31:0]        mat_rd, rhs_rd, prev_rd, cur_rd, next_rd;
  logic signed [31:0] mat_q, rhs_q, prev_q, cur_q, next_q;
  logic               mat_we, rhs_we, cur_we, prev_we, next_we;
  logic [MAW-1:0]     mat_waddr, mat_raddr;
  logic [IW-1:0]      cur_raddr;
  logic [31:0]        cur_wdata, prev_wdata;

  crs_pkg::div_req_t div_req;
  crs_pkg::div_rsp_t div_rsp;

  always_comb begin
    if (size_r == 5'd0) n_act = NW'(1);
    else if (32'(size_r) > 32'(MAX_UNKNOWNS)) n_act = NW'(MAX_UNKNOWNS);
    else n_act = NW'(size_r);
  end

  assign n_p     = POSW'(n_act);
  assign n1_p    = n_p + 1'b1;
  assign total   = POSW'(32'(n_act) * (32'(n_act) + 32'd1));
  assign n_m1    = IW'(n_act - 1'b1);
  assign busy    = (state_r != S_IDLE) || resync_r || out_valid_r;
  assign accept  = start && !busy;
  assign lim_eff = (lim_r == 16'd0) ? 16'd1 : lim_r;

  assign mat_q  = mat_rd;
  assign rhs_q  = rhs_rd;
  assign prev_q = prev_rd;
  assign cur_q  = cur_rd;
  assign next_q = next_rd;

  assign s_sum  = 32'(alpha_r) + 32'(beta_r);
  assign diff_s = $signed({2'b00, beta_r}) - $signed({2'b00, alpha_r});
  assign den_c  = 35'(t1_r) + 35'(t1_r) - 35'(omega_r);
  assign qm     = crs_pkg::sat32(66'(prod_r >>> FRACTION_BITS));
  assign coef   = crs_pkg::sat32((66'sd1 <<< FRACTION_BITS) + 66'(w_r));
  assign x2     = crs_pkg::sat32(66'(cur_i_r) + 66'(t1v_r) - 66'(qm));
  assign ch_s   = 34'(x2) - 34'(cur_i_r);
  assign ch_abs = ch_s[33] ? 33'(-ch_s) : 33'(ch_s);

  always_comb begin
    unique case (state_r)
      S_X1_MUL: begin mul_a = d_r;     mul_b = rhs_q; end
      S_IT_W:   begin mul_a = omega_r; mul_b = om1_r; end
      S_IT_D:   begin mul_a = d_r;     mul_b = coef;  end
      S_MV_MUL: begin mul_a = mat_q;   mul_b = cur_q; end
      S_RW_B:   begin mul_a = w_r;     mul_b = dif_r; end
      S_RW_C:   begin mul_a = dc_r;    mul_b = r_r;   end
      default:  begin mul_a = '0;      mul_b = '0;    end
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    div_req.go = (state_r == S_DIV_GO);
    unique case (sel_r)
      SEL_D: begin
        div_req.num = 64'sd1 <<< (2 * FRACTION_BITS + 1);
        div_req.den = 35'($signed({1'b0, s_sum}));
      end
      SEL_T: begin
        div_req.num = -(64'($signed({1'b0, s_sum})) <<< FRACTION_BITS);
        div_req.den = 35'(diff_s);
      end
      SEL_OM: begin
        div_req.num = -(64'(diff_s) <<< FRACTION_BITS);
        div_req.den = 35'($signed({1'b0, s_sum}));
      end
      SEL_OM1: begin
        div_req.num = 64'sd1 <<< (2 * FRACTION_BITS);
        div_req.den = den_r;
      end
      default: begin
        div_req.num = '0;
        div_req.den = '0;
      end
    endcase
  end

  assign mat_we    = accept && (col_r < n_p);
  assign rhs_we    = accept && (col_r >= n_p);
  assign mat_waddr = MAW'(32'(row_r) * MAX_UNKNOWNS + 32'(col_r));
  assign mat_raddr = MAW'(32'(i_r) * MAX_UNKNOWNS + 32'(j_r));
  assign cur_raddr = (state_r == S_MV_RD) ? j_r : i_r;
  assign cur_we    = (state_r == S_X1_WR) || (state_r == S_CP_WR);
  assign prev_we   = cur_we;
  assign next_we   = (state_r == S_RW_D);
  assign cur_wdata  = (state_r == S_X1_WR) ? qm : next_q;
  assign prev_wdata = (state_r == S_X1_WR) ? 32'd0 : cur_q;

  crs_ram #(.W(32), .DEPTH(MD)) u_mat (
    .clk, .we(mat_we), .waddr(mat_waddr), .wdata(in_load_value),
    .raddr(mat_raddr), .rdata(mat_rd)
  );
  crs_ram #(.W(32), .DEPTH(MAX_UNKNOWNS)) u_rhs (
    .clk, .we(rhs_we), .waddr(row_r), .wdata(in_load_value),
    .raddr(i_r), .rdata(rhs_rd)
  );
  crs_ram #(.W(32), .DEPTH(MAX_UNKNOWNS)) u_prev (
    .clk, .we(prev_we), .waddr(i_r), .wdata(prev_wdata),
    .raddr(i_r), .rdata(prev_rd)
  );
  crs_ram #(.W(32), .DEPTH(MAX_UNKNOWNS)) u_cur (
    .clk, .we(cur_we), .waddr(i_r), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rd)
  );
  crs_ram #(.W(32), .DEPTH(MAX_UNKNOWNS)) u_next (
    .clk, .we(next_we), .waddr(i_r), .wdata(x2),
    .raddr(i_r), .rdata(next_rd)
  );

  crs_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_D;
      size_r      <= 5'd1;
      alpha_r     <= 31'd65536;
      beta_r      <= 31'd131072;
      tol_r       <= 31'd66;
      lim_r       <= 16'd1000;
      resync_r    <= 1'b0;
      pos_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      iter_r      <= '0;
      omega_r     <= '0;
      met_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_OUT_EM);
      prod_r      <= prod_nxt;
      resync_r    <= (cfg_we && cfg_index == crs_pkg::CFG_SIZE) ||
                     (resync_r && state_r != S_IDLE);
      if (cfg_we) begin
        unique case (cfg_index)
          crs_pkg::CFG_SIZE:  size_r  <= cfg_data[4:0];
          crs_pkg::CFG_ALPHA: alpha_r <= cfg_data;
          crs_pkg::CFG_BETA:  beta_r  <= cfg_data;
          crs_pkg::CFG_TOL:   tol_r   <= cfg_data;
          crs_pkg::CFG_LIMIT: lim_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (resync_r) begin
            row_r    <= '0;
            state_r  <= S_RESYNC;
            if (pos_r >= total) begin
              pos_r <= '0;
              col_r <= '0;
            end else begin
              col_r <= pos_r;
            end
          end else if (accept) begin
            if (pos_r + 1'b1 == total) begin
              pos_r   <= '0;
              col_r   <= '0;
              row_r   <= '0;
              state_r <= S_SETUP;
            end else begin
              pos_r <= pos_r + 1'b1;
              if (col_r >= n_p) begin
                col_r <= '0;
                row_r <= row_r + 1'b1;
              end else begin
                col_r <= col_r + 1'b1;
              end
            end
          end
        end
        S_RESYNC: begin
          if (col_r >= n1_p) begin
            col_r <= col_r - n1_p;
            row_r <= row_r + 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SETUP: begin
          iter_r <= '0;
          met_r  <= 1'b0;
          i_r    <= '0;
          if (s_sum == 32'd0 || diff_s == 33'sd0) begin
            bad_r   <= 1'b1;
            omega_r <= '0;
            state_r <= S_OUT_RD;
          end else begin
            bad_r   <= 1'b0;
            sel_r   <= SEL_D;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WT;
        S_DIV_WT: begin
          if (div_rsp.done) begin
            unique case (sel_r)
              SEL_D: begin
                d_r     <= div_rsp.quo;
                sel_r   <= SEL_T;
                state_r <= S_DIV_GO;
              end
              SEL_T: begin
                t1_r    <= div_rsp.quo;
                sel_r   <= SEL_OM;
                state_r <= S_DIV_GO;
              end
              SEL_OM: begin
                omega_r <= div_rsp.quo;
                i_r     <= '0;
                state_r <= S_X1_RD;
              end
              SEL_OM1: begin
                om1_r   <= div_rsp.quo;
                state_r <= S_IT_W;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_X1_RD:  state_r <= S_X1_MUL;
        S_X1_MUL: state_r <= S_X1_WR;
        S_X1_WR: begin
          if (i_r == n_m1) begin
            state_r <= S_IT_DEN;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_X1_RD;
          end
        end
        S_IT_DEN: begin
          i_r <= '0;
          if (den_c == 35'sd0) begin
            met_r   <= 1'b0;
            state_r <= S_OUT_RD;
          end else begin
            den_r   <= den_c;
            sel_r   <= SEL_OM1;
            state_r <= S_DIV_GO;
          end
        end
        S_IT_W: state_r <= S_IT_C;
        S_IT_C: begin
          w_r     <= qm;
          state_r <= S_IT_D;
        end
        S_IT_D: state_r <= S_IT_E;
        S_IT_E: begin
          dc_r    <= qm;
          i_r     <= '0;
          j_r     <= '0;
          acc_r   <= '0;
          norm_r  <= '0;
          state_r <= S_MV_RD;
        end
        S_MV_RD:  state_r <= S_MV_MUL;
        S_MV_MUL: state_r <= S_MV_ACC;
        S_MV_ACC: begin
          acc_r <= acc_r + 40'(qm);
          if (j_r == n_m1) begin
            state_r <= S_RW_RD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_MV_RD;
          end
        end
        S_RW_RD: state_r <= S_RW_A;
        S_RW_A: begin
          cur_i_r <= cur_q;
          r_r     <= crs_pkg::sat32(66'(crs_pkg::sat32(66'(acc_r))) - 66'(rhs_q));
          dif_r   <= crs_pkg::sat32(66'(cur_q) - 66'(prev_q));
          state_r <= S_RW_B;
        end
        S_RW_B: state_r <= S_RW_C;
        S_RW_C: begin
          t1v_r   <= qm;
          state_r <= S_RW_D;
        end
        S_RW_D: begin
          if (ch_abs > norm_r) norm_r <= ch_abs;
          j_r   <= '0;
          acc_r <= '0;
          if (i_r == n_m1) begin
            i_r     <= '0;
            state_r <= S_CP_RD;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_MV_RD;
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          if (i_r == n_m1) begin
            state_r <= S_IT_END;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_CP_RD;
          end
        end
        S_IT_END: begin
          omega_r <= om1_r;
          iter_r  <= iter_r + 1'b1;
          i_r     <= '0;
          if (norm_r <= {2'b00, tol_r}) begin
            met_r   <= 1'b1;
            state_r <= S_OUT_RD;
          end else if (iter_r + 1'b1 >= lim_eff) begin
            met_r   <= 1'b0;
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_IT_DEN;
          end
        end
        S_OUT_RD: state_r <= S_OUT_EM;
        S_OUT_EM: begin
          out_val_r   <= bad_r ? 32'sd0 : cur_q;
          out_idx_r   <= 4'(i_r);
          out_iter_r  <= iter_r;
          out_conv_r  <= met_r;
          out_last_r  <= (i_r == n_m1);
          if (i_r == n_m1) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_OUT_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_solution_value  = out_val_r;
  assign out_element_index   = out_idx_r;
  assign out_iteration_count = out_iter_r;
  assign out_converged       = out_conv_r;
  assign out_last_of_run     = out_last_r;

endmodule

>>> src/crs_checker.sv
// Port-level checker for the solver, bound to the top level
`include "chebyshev_richardson_solver_defines.svh"

module crs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_converged,
  input logic [15:0] out_iteration_count,
  input logic        out_last_of_run
);

  `CRS_CHK(a_result_while_busy, out_valid, busy)
  `CRS_CHK_NXT(a_gap_after_last, out_valid && out_last_of_run, !out_valid)
  `CRS_CHK(a_conv_needs_iter, out_valid && out_converged, out_iteration_count != 16'd0)
  `CRS_CHK_RST(a_reset_quiet, !rst_n, !out_valid && !busy)

endmodule

bind chebyshev_richardson_solver crs_checker u_crs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .busy(busy),
  .out_valid(out_valid),
  .out_converged(out_converged),
  .out_iteration_count(out_iteration_count),
  .out_last_of_run(out_last_of_run)
);
